// File: design/dsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared widths, types and register codes of the damped spring force core.
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam int COORD_W    = 32;             // Q16.16 coordinate / velocity
    localparam int MAG_D_W    = 32;             // magnitude of a position delta
    localparam int RAD_W      = 66;             // sum of three squares
    localparam int LEN_W      = 33;             // floor square root of RAD_W bits
    localparam int SQ_STAGES  = LEN_W;          // one root bit per stage
    localparam int Q_W        = 31;             // unit vector magnitude, Q1.30
    localparam int DIV_STAGES = Q_W;            // one quotient bit per stage
    localparam int COEF_W     = 31;             // stiffness, damping, rest length
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LEN  = 2'd2;

    localparam logic [COEF_W-1:0] RST_STIFFNESS = 31'd1310720;
    localparam logic [COEF_W-1:0] RST_DAMPING   = 31'd13107;
    localparam logic [COEF_W-1:0] RST_REST_LEN  = 31'd65536;

    // sideband that rides along the root and divide pipelines
    typedef struct packed {
        logic [2:0]               neg;   // delta sign per axis
        logic [2:0][MAG_D_W-1:0]  mag;   // delta magnitude per axis
        logic [5:0][COORD_W-1:0]  vel;   // first vel x/y/z, second vel x/y/z
    } t_side;

endpackage
`default_nettype wire

// File: design/dsf_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_sqrt
// Pipelined floor square root, one restoring step (one root bit) per stage.
// ----------------------------------------------------------------------------
module dsf_sqrt import dsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [RAD_W-1:0] i_rad,
    input  t_side            i_side,
    output logic             o_vld,
    output logic [LEN_W-1:0] o_root,
    output t_side            o_side
);

    logic             r_vld  [1:SQ_STAGES];
    logic [LEN_W-1:0] r_root [1:SQ_STAGES];
    logic [LEN_W+1:0] r_rem  [1:SQ_STAGES];
    logic [RAD_W-1:0] r_rad  [1:SQ_STAGES];
    t_side            r_side [1:SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
        localparam int Pos = 2 * (SQ_STAGES - 1 - k);
        logic             p_vld;
        logic [LEN_W-1:0] p_root;
        logic [LEN_W+1:0] p_rem;
        logic [RAD_W-1:0] p_rad;
        t_side            p_side;
        logic [LEN_W+3:0] w_cur;
        logic [LEN_W+3:0] w_trial;
        logic [LEN_W+3:0] w_diff;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_root = '0;
            assign p_rem  = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k];
            assign p_root = r_root[k];
            assign p_rem  = r_rem[k];
            assign p_rad  = r_rad[k];
            assign p_side = r_side[k];
        end

        assign w_cur   = {p_rem, p_rad[Pos+1:Pos]};
        assign w_trial = {2'b00, p_root, 2'b01};
        assign w_diff  = w_cur - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1]  <= p_rad;
                r_side[k+1] <= p_side;
                if (w_cur >= w_trial) begin
                    r_rem[k+1]  <= w_diff[LEN_W+1:0];
                    r_root[k+1] <= {p_root[LEN_W-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= w_cur[LEN_W+1:0];
                    r_root[k+1] <= {p_root[LEN_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_vld[SQ_STAGES];
    assign o_root = r_root[SQ_STAGES];
    assign o_side = r_side[SQ_STAGES];

endmodule
`default_nettype wire

// File: design/dsf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_div
// Three-lane pipelined restoring divider: q = (mag << 30) / len, one bit/stage.
// ----------------------------------------------------------------------------
module dsf_div import dsf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [LEN_W-1:0]     i_len,
    input  t_side                i_side,
    output logic                 o_vld,
    output logic [LEN_W-1:0]     o_len,
    output logic [2:0][Q_W-1:0]  o_q,
    output t_side                o_side
);

    logic                    r_vld  [1:DIV_STAGES];
    logic [LEN_W-1:0]        r_len  [1:DIV_STAGES];
    logic [2:0][LEN_W-1:0]   r_rem  [1:DIV_STAGES];
    logic [2:0][Q_W-1:0]     r_q    [1:DIV_STAGES];
    t_side                   r_side [1:DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
        logic                  p_vld;
        logic [LEN_W-1:0]      p_len;
        logic [2:0][LEN_W-1:0] p_rem;
        logic [2:0][Q_W-1:0]   p_q;
        t_side                 p_side;
        logic [2:0]            p_bit;

        if (k == 0) begin : g_first
            // m <= len, so (m << 30) >> 31 is already below the divisor
            assign p_vld  = i_vld;
            assign p_len  = i_len;
            assign p_q    = '0;
            assign p_side = i_side;
            for (genvar l = 0; l < 3; l++) begin : g_init
                assign p_rem[l] = {2'b00, i_side.mag[l][MAG_D_W-1:1]};
                assign p_bit[l] = i_side.mag[l][0];
            end
        end else begin : g_next
            assign p_vld  = r_vld[k];
            assign p_len  = r_len[k];
            assign p_rem  = r_rem[k];
            assign p_q    = r_q[k];
            assign p_side = r_side[k];
            assign p_bit  = '0;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= p_vld;
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [LEN_W:0] w_cur;
            logic [LEN_W:0] w_diff;
            assign w_cur  = {p_rem[l], p_bit[l]};
            assign w_diff = w_cur - {1'b0, p_len};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_cur >= {1'b0, p_len}) begin
                        r_rem[k+1][l] <= w_diff[LEN_W-1:0];
                        r_q[k+1][l]   <= {p_q[l][Q_W-2:0], 1'b1};
                    end else begin
                        r_rem[k+1][l] <= w_cur[LEN_W-1:0];
                        r_q[k+1][l]   <= {p_q[l][Q_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[k+1]  <= p_len;
                r_side[k+1] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[DIV_STAGES];
    assign o_len  = r_len[DIV_STAGES];
    assign o_q    = r_q[DIV_STAGES];
    assign o_side = r_side[DIV_STAGES];

endmodule
`default_nettype wire

// File: design/damped_spring_force_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// damped_spring_force_core
// Hooke spring with linear damper: force on the first of two particles.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one request per spring, twelve signed Q16.16
//   words: first pos, second pos, first vel, second vel (x, y, z each).
//   Output stream (m_axis): force on the first particle (x, y, z, signed
//   Q16.16, saturated) in tdata, degenerate flag in tuser. Coincident
//   particles give zero force with the flag set.
//   Config channel: index 0 stiffness, 1 damping, 2 rest length (unsigned
//   Q16.16, bit 31 dropped); index 3 is ignored. Always ready. Write only
//   while the pipe is empty.
// Timing:
//   Fully pipelined, one request per clock while m_axis is not stalled.
//   77 register stages: delta (1), squares (1), sum (1), square root
//   (33, one bit per stage), three-lane divide for the unit vector (31,
//   one bit per stage), projection and force math (9), output register (1).
// Reset / stall:
//   Synchronous reset clears all valid bits and loads the register defaults
//   (20.0, about 0.2, 1.0). A stalled output freezes the whole pipe with one
//   common enable; s_axis_tready drops only while the output is held.
// ----------------------------------------------------------------------------
module damped_spring_force_core import dsf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // fields low to high: first_pos_x, first_pos_y, first_pos_z,
    // second_pos_x, second_pos_y, second_pos_z, first_vel_x, first_vel_y,
    // first_vel_z, second_vel_x, second_vel_y, second_vel_z
    input  logic [383:0]         s_axis_tdata,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // fields low to high: force_x, force_y, force_z
    output logic [95:0]          m_axis_tdata,
    // fields: degenerate
    output logic                 m_axis_tuser,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic w_en;

    // config registers
    logic [COEF_W-1:0] r_stiffness;
    logic [COEF_W-1:0] r_damping;
    logic [COEF_W-1:0] r_rest_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness <= RST_STIFFNESS;
            r_damping   <= RST_DAMPING;
            r_rest_len  <= RST_REST_LEN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STIFFNESS: r_stiffness <= i_cfg_data[COEF_W-1:0];
                CFG_DAMPING:   r_damping   <= i_cfg_data[COEF_W-1:0];
                CFG_REST_LEN:  r_rest_len  <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // --------------------------------------------------------------------
    // Stage A: deltas d = second - first (33-bit), split into sign/mag.
    // --------------------------------------------------------------------
    logic  r_a_vld;
    t_side r_a_side;
    t_side n_a_side;

    always_comb begin
        logic [COORD_W:0] d;
        n_a_side = '0;
        for (int l = 0; l < 3; l++) begin
            d = {s_axis_tdata[(l+3)*32+31], s_axis_tdata[(l+3)*32 +: 32]}
              - {s_axis_tdata[l*32+31], s_axis_tdata[l*32 +: 32]};
            n_a_side.neg[l] = d[COORD_W];
            n_a_side.mag[l] = d[COORD_W] ? (~d[MAG_D_W-1:0] + 32'd1) : d[MAG_D_W-1:0];
        end
        for (int v = 0; v < 6; v++) begin
            n_a_side.vel[v] = s_axis_tdata[(v+6)*32 +: 32];
        end
    end

    // Stage B: squares. Stage C: sum of squares.
    logic                 r_b_vld;
    t_side                r_b_side;
    logic [2:0][63:0]     r_b_sq;
    logic                 r_c_vld;
    t_side                r_c_side;
    logic [RAD_W-1:0]     r_c_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= s_axis_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_side <= n_a_side;
            r_b_side <= r_a_side;
            for (int l = 0; l < 3; l++) begin
                r_b_sq[l] <= r_a_side.mag[l] * r_a_side.mag[l];
            end
            r_c_side <= r_b_side;
            r_c_sum  <= {2'b00, r_b_sq[0]} + {2'b00, r_b_sq[1]} + {2'b00, r_b_sq[2]};
        end
    end

    // --------------------------------------------------------------------
    // Length and unit vector
    // --------------------------------------------------------------------
    logic             w_sq_vld;
    logic [LEN_W-1:0] w_sq_len;
    t_side            w_sq_side;

    dsf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_c_vld),
        .i_rad   (r_c_sum),
        .i_side  (r_c_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_len),
        .o_side  (w_sq_side)
    );

    logic                w_dv_vld;
    logic [LEN_W-1:0]    w_dv_len;
    logic [2:0][Q_W-1:0] w_dv_q;
    t_side               w_dv_side;

    dsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_len   (w_sq_len),
        .i_side  (w_sq_side),
        .o_vld   (w_dv_vld),
        .o_len   (w_dv_len),
        .o_q     (w_dv_q),
        .o_side  (w_dv_side)
    );

    // --------------------------------------------------------------------
    // M1: signed u (Q2.30) times each velocity.
    // --------------------------------------------------------------------
    logic [8:0]              r_m_vld;     // valid of M1..M9
    logic [2:0][31:0]        n_m1_u;
    logic [2:0][63:0]        r_m1_p1;
    logic [2:0][63:0]        r_m1_p2;
    logic [2:0]              r_m1_uneg;
    logic [2:0][Q_W-1:0]     r_m1_q;
    logic [LEN_W-1:0]        r_m1_len;
    logic                    r_m1_deg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_m1_u[l] = w_dv_side.neg[l] ? (32'd0 - {1'b0, w_dv_q[l]}) : {1'b0, w_dv_q[l]};
        end
    end

    // M2: dot-product sums, length error.
    logic signed [RAD_W-1:0] r_m2_v1;
    logic signed [RAD_W-1:0] r_m2_v2;
    logic signed [34:0]      r_m2_e;
    logic [2:0]              r_m2_uneg;
    logic [2:0][Q_W-1:0]     r_m2_q;
    logic                    r_m2_deg;

    // M3: truncate toward zero to Q16.16, velocity difference.
    logic signed [RAD_W-1:0] n_m3_t1;
    logic signed [RAD_W-1:0] n_m3_t2;
    logic signed [36:0]      r_m3_dv;
    logic signed [34:0]      r_m3_e;
    logic [2:0]              r_m3_uneg;
    logic [2:0][Q_W-1:0]     r_m3_q;
    logic                    r_m3_deg;

    localparam logic [RAD_W-1:0] TRUNC_BIAS = {{(RAD_W-30){1'b0}}, 30'h3FFF_FFFF};

    assign n_m3_t1 = r_m2_v1 + (r_m2_v1[RAD_W-1] ? $signed(TRUNC_BIAS) : $signed(RAD_W'(0)));
    assign n_m3_t2 = r_m2_v2 + (r_m2_v2[RAD_W-1] ? $signed(TRUNC_BIAS) : $signed(RAD_W'(0)));

    // M4: magnitudes. M5: coefficient partial products. M6: scalar force.
    logic [36:0]             r_m4_me;
    logic [36:0]             r_m4_md;
    logic                    r_m4_en;
    logic                    r_m4_dn;
    logic [2:0]              r_m4_uneg;
    logic [2:0][Q_W-1:0]     r_m4_q;
    logic                    r_m4_deg;

    logic [52:0]             r_m5_ks_hi;
    logic [52:0]             r_m5_ks_lo;
    logic [52:0]             r_m5_kd_hi;
    logic [52:0]             r_m5_kd_lo;
    logic                    r_m5_en;
    logic                    r_m5_dn;
    logic [2:0]              r_m5_uneg;
    logic [2:0][Q_W-1:0]     r_m5_q;
    logic                    r_m5_deg;

    logic [52:0]             n_m6_pk;
    logic [52:0]             n_m6_pd;
    logic signed [54:0]      n_m6_sk;
    logic signed [54:0]      n_m6_sd;
    logic signed [54:0]      r_m6_f;
    logic [2:0]              r_m6_uneg;
    logic [2:0][Q_W-1:0]     r_m6_q;
    logic                    r_m6_deg;

    assign n_m6_pk = r_m5_ks_hi + {16'd0, r_m5_ks_lo[52:16]};
    assign n_m6_pd = r_m5_kd_hi + {16'd0, r_m5_kd_lo[52:16]};
    assign n_m6_sk = r_m5_en ? -$signed({2'b00, n_m6_pk}) : $signed({2'b00, n_m6_pk});
    assign n_m6_sd = r_m5_dn ? -$signed({2'b00, n_m6_pd}) : $signed({2'b00, n_m6_pd});

    // M7: |F|. M8: F*u partial products. M9: combine, sign, saturate.
    logic [53:0]             r_m7_fm;
    logic                    r_m7_fneg;
    logic [2:0]              r_m7_uneg;
    logic [2:0][Q_W-1:0]     r_m7_q;
    logic                    r_m7_deg;

    logic [2:0][54:0]        r_m8_hi;
    logic [2:0][60:0]        r_m8_lo;
    logic [2:0]              r_m8_neg;
    logic                    r_m8_deg;

    logic [2:0][31:0]        n_m9_force;
    logic [2:0][31:0]        r_m9_force;
    logic                    r_m9_deg;

    always_comb begin
        logic [55:0] p;
        for (int l = 0; l < 3; l++) begin
            p = {1'b0, r_m8_hi[l]} + {25'd0, r_m8_lo[l][60:30]};
            if (r_m8_neg[l]) begin
                n_m9_force[l] = (p > 56'h8000_0000) ? 32'h8000_0000 : (32'd0 - p[31:0]);
            end else begin
                n_m9_force[l] = (p > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= '0;
        end else if (w_en) begin
            r_m_vld <= {r_m_vld[7:0], w_dv_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // M1
            for (int l = 0; l < 3; l++) begin
                r_m1_p1[l]   <= 64'($signed(n_m1_u[l]) * $signed(w_dv_side.vel[l]));
                r_m1_p2[l]   <= 64'($signed(n_m1_u[l]) * $signed(w_dv_side.vel[l+3]));
                r_m1_uneg[l] <= w_dv_side.neg[l] && (w_dv_q[l] != '0);
            end
            r_m1_q   <= w_dv_q;
            r_m1_len <= w_dv_len;
            r_m1_deg <= (w_dv_len == '0);
            // M2
            r_m2_v1   <= RAD_W'($signed(r_m1_p1[0])) + RAD_W'($signed(r_m1_p1[1]))
                       + RAD_W'($signed(r_m1_p1[2]));
            r_m2_v2   <= RAD_W'($signed(r_m1_p2[0])) + RAD_W'($signed(r_m1_p2[1]))
                       + RAD_W'($signed(r_m1_p2[2]));
            r_m2_e    <= $signed({2'b00, r_m1_len}) - $signed({4'd0, r_rest_len});
            r_m2_uneg <= r_m1_uneg;
            r_m2_q    <= r_m1_q;
            r_m2_deg  <= r_m1_deg;
            // M3: each sum is divided by 2^30 on its own, then differenced
            r_m3_dv   <= $signed({n_m3_t2[RAD_W-1], n_m3_t2[RAD_W-1:30]})
                       - $signed({n_m3_t1[RAD_W-1], n_m3_t1[RAD_W-1:30]});
            r_m3_e    <= r_m2_e;
            r_m3_uneg <= r_m2_uneg;
            r_m3_q    <= r_m2_q;
            r_m3_deg  <= r_m2_deg;
            // M4
            r_m4_en   <= r_m3_e[34];
            r_m4_me   <= r_m3_e[34] ? 37'(-{{2{r_m3_e[34]}}, r_m3_e}) : {2'b00, r_m3_e};
            r_m4_dn   <= r_m3_dv[36];
            r_m4_md   <= r_m3_dv[36] ? 37'(-r_m3_dv) : r_m3_dv;
            r_m4_uneg <= r_m3_uneg;
            r_m4_q    <= r_m3_q;
            r_m4_deg  <= r_m3_deg;
            // M5
            r_m5_ks_hi <= 53'(r_stiffness[30:16] * r_m4_me);
            r_m5_ks_lo <= 53'(r_stiffness[15:0]  * r_m4_me);
            r_m5_kd_hi <= 53'(r_damping[30:16]   * r_m4_md);
            r_m5_kd_lo <= 53'(r_damping[15:0]    * r_m4_md);
            r_m5_en    <= r_m4_en;
            r_m5_dn    <= r_m4_dn;
            r_m5_uneg  <= r_m4_uneg;
            r_m5_q     <= r_m4_q;
            r_m5_deg   <= r_m4_deg;
            // M6
            r_m6_f    <= n_m6_sk + n_m6_sd;
            r_m6_uneg <= r_m5_uneg;
            r_m6_q    <= r_m5_q;
            r_m6_deg  <= r_m5_deg;
            // M7
            r_m7_fneg <= r_m6_f[54];
            r_m7_fm   <= r_m6_f[54] ? 54'(-r_m6_f) : r_m6_f[53:0];
            r_m7_uneg <= r_m6_uneg;
            r_m7_q    <= r_m6_q;
            r_m7_deg  <= r_m6_deg;
            // M8
            for (int l = 0; l < 3; l++) begin
                r_m8_hi[l]  <= r_m7_fm[53:30] * r_m7_q[l];
                r_m8_lo[l]  <= r_m7_fm[29:0]  * r_m7_q[l];
                r_m8_neg[l] <= r_m7_fneg ^ r_m7_uneg[l];
            end
            r_m8_deg <= r_m7_deg;
            // M9
            r_m9_force <= n_m9_force;
            r_m9_deg   <= r_m8_deg;
        end
    end

    // --------------------------------------------------------------------
    // Output register; the whole pipe advances whenever it can drain.
    // --------------------------------------------------------------------
    logic            r_out_vld;
    logic [95:0]     r_out_data;
    logic            r_out_deg;

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_m_vld[8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= r_m9_deg ? '0 : r_m9_force;
            r_out_deg  <= r_m9_deg;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_deg;

    // --------------------------------------------------------------------
    // Assertions
    // --------------------------------------------------------------------
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate result carries nonzero force");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_m_vld) && $stable(r_m9_force))
        else $error("pipeline moved during output stall");

    a_len_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && w_dv_vld |=> r_m1_deg == (r_m1_len == '0))
        else $error("degenerate flag does not match length");

endmodule
`default_nettype wire
